// ===== src/acs_pkg.sv =====
// Shared types and constants for the adaptive cleanup scheduler.
// Used by the controller, the datapath, the divider and the top level.
package acs_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 64;
  localparam int unsigned TGT_W   = 12;
  localparam int unsigned IDX_W   = 3;

  // 2*target*interval, and 5*diff
  localparam int unsigned PROD_W = TGT_W + 1 + WORD_W;
  localparam int unsigned DEN_W  = WORD_W + 3;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // interval/5 as (interval * ceil(2^34/5)) >> 34, exact for 32-bit operands
  localparam logic [WORD_W-1:0] RECIP_FIVE  = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP_SHIFT = 34;
  localparam int unsigned       FIFTH_W     = COUNT_W - RECIP_SHIFT;

  localparam logic [WORD_W-1:0] MIN_RST    = 32'd1000;
  localparam logic [WORD_W-1:0] MAX_RST    = 32'd300000;
  localparam logic [WORD_W-1:0] INIT_RST   = 32'd4096;
  localparam logic [WORD_W-1:0] START_RST  = 32'd0;
  localparam logic [TGT_W-1:0]  TARGET_RST = 12'd30;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MIN_INTERVAL     = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_INTERVAL     = 3'd1;
  localparam logic [IDX_W-1:0] REG_INITIAL_INTERVAL = 3'd2;
  localparam logic [IDX_W-1:0] REG_TARGET_SECONDS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_START_TIME       = 3'd4;

  typedef struct packed {
    logic take_in;
    logic emit_plain;
    logic calc_diff;
    logic load_ops;
    logic div_start;
    logic latch_q1;
    logic latch_q2;
    logic sum;
    logic raise;
    logic lower;
    logic clear_skip;
    logic finish_skip;
    logic finish_clean;
  } acs_cmd_t;

  typedef struct packed {
    logic hit;
    logic skip_cond;
    logic skip_flag;
    logic div_done;
    logic out_free;
  } acs_stat_t;

endpackage

// ===== src/acs_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on acs_pkg for default widths.
module acs_div import acs_pkg::*; #(
  parameter int unsigned NUM_W = PROD_W,
  parameter int unsigned DEN_W_P = DEN_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W_P-1:0] den,
  output logic               done,
  output logic [NUM_W-1:0]   quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DEN_W_P-1:0] rem;
  logic [DEN_W_P-1:0] dsr;
  logic [NUM_W-1:0]   qn;
  logic [DEN_W_P:0]   trial;
  logic               ge;

  assign trial = {rem, qn[NUM_W-1]};
  assign ge    = (trial >= {1'b0, dsr});
  assign quo   = qn;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= den;
      qn  <= num;
    end else if (busy) begin
      // remainder stays below the divisor, so the top trial bit drops out
      rem <= ge ? DEN_W_P'(trial - {1'b0, dsr}) : trial[DEN_W_P-1:0];
      qn  <= {qn[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== src/acs_datapath.sv =====
// Datapath: configuration, counters, interval adaptation and result register.
// Depends on acs_pkg; instantiates acs_div.
module acs_datapath import acs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic [WORD_W-1:0] now_seconds,
  input  acs_cmd_t          cmd,
  output acs_stat_t         stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              do_clean,
  output logic              clean_skipped,
  output logic [WORD_W-1:0] interval_now
);

  logic [WORD_W-1:0]  min_interval;
  logic [WORD_W-1:0]  max_interval;
  logic [TGT_W-1:0]   target_seconds;
  logic [COUNT_W-1:0] op_count;
  logic [COUNT_W-1:0] next_mark;
  logic [WORD_W-1:0]  interval;
  logic [WORD_W-1:0]  last_clean_time;
  logic               skip_flag;
  logic [WORD_W-1:0]  now_r;
  logic [WORD_W-1:0]  diff;
  logic [PROD_W-1:0]  prod;
  logic [DEN_W-1:0]   den;
  logic [WORD_W-1:0]  q1;
  logic [PROD_W-1:0]  q2;
  logic [SUM_W-1:0]   acc;

  logic [COUNT_W-1:0] recip_prod;
  logic [FIFTH_W-1:0] fifth;
  logic [WORD_W-1:0]  fifth_rem;
  logic [1:0]         rem_bump;

  logic [PROD_W-1:0]  div_quo;
  logic               div_done;

  acs_div #(.NUM_W(PROD_W), .DEN_W_P(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // 3*i/5 = 3*(i/5) + 3*(i%5)/5
  assign recip_prod = COUNT_W'(interval) * COUNT_W'(RECIP_FIVE);
  assign fifth_rem  = interval - ({fifth, 2'b00} + WORD_W'(fifth));
  assign rem_bump   = (fifth_rem >= WORD_W'(4)) ? 2'd2 :
                      (fifth_rem >= WORD_W'(2)) ? 2'd1 : 2'd0;

  assign stat.hit       = (op_count == next_mark);
  assign stat.skip_cond = (interval == max_interval) && (diff < WORD_W'(target_seconds));
  assign stat.skip_flag = skip_flag;
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || out_ready;

  // configuration and scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval    <= MIN_RST;
      max_interval    <= MAX_RST;
      target_seconds  <= TARGET_RST;
      op_count        <= '0;
      next_mark       <= COUNT_W'(INIT_RST);
      interval        <= INIT_RST;
      last_clean_time <= START_RST;
      skip_flag       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_INTERVAL: min_interval <= cfg_data;
          REG_MAX_INTERVAL: max_interval <= cfg_data;
          REG_INITIAL_INTERVAL: begin
            interval  <= cfg_data;
            next_mark <= COUNT_W'(cfg_data);
          end
          REG_TARGET_SECONDS: target_seconds <= cfg_data[TGT_W-1:0];
          REG_START_TIME: last_clean_time <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take_in) begin
        op_count <= op_count + COUNT_W'(1);
      end
      if (cmd.lower) begin
        interval <= (acc > SUM_W'(max_interval)) ? max_interval : acc[WORD_W-1:0];
      end
      if (cmd.clear_skip) begin
        skip_flag <= 1'b0;
      end
      if (cmd.finish_skip) begin
        skip_flag <= 1'b1;
        next_mark <= next_mark + COUNT_W'(interval);
      end
      if (cmd.finish_clean) begin
        next_mark       <= next_mark + COUNT_W'(interval);
        last_clean_time <= now_r;
      end
    end
  end

  // working registers of the adaptation
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      now_r <= now_seconds;
    end
    if (cmd.calc_diff) begin
      diff <= (now_r > last_clean_time) ? (now_r - last_clean_time) : WORD_W'(1);
    end
    if (cmd.load_ops) begin
      prod  <= PROD_W'({target_seconds, 1'b0}) * PROD_W'(interval);
      den   <= {diff, 2'b00} + DEN_W'(diff);
      fifth <= recip_prod[COUNT_W-1:RECIP_SHIFT];
    end
    if (cmd.latch_q1) begin
      q1 <= WORD_W'({fifth, 1'b0}) + WORD_W'(fifth) + WORD_W'(rem_bump);
    end
    if (cmd.latch_q2) begin
      q2 <= div_quo;
    end
    if (cmd.sum) begin
      acc <= SUM_W'(q1) + SUM_W'(q2);
    end
    if (cmd.raise) begin
      if (acc < SUM_W'(min_interval)) begin
        acc <= SUM_W'(min_interval);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_plain || cmd.finish_skip || cmd.finish_clean) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_plain || cmd.finish_skip || cmd.finish_clean) begin
      do_clean      <= cmd.finish_clean;
      clean_skipped <= cmd.finish_skip;
      interval_now  <= interval;
    end
  end

endmodule

// ===== src/acs_ctrl.sv =====
// Controller state machine: accepts requests and sequences a clean point through the datapath.
// Depends on acs_pkg for the command and status structs.
module acs_ctrl import acs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  acs_stat_t stat,
  output acs_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DIFF   = 11'b00000000010,
    S_DECIDE = 11'b00000000100,
    S_MUL    = 11'b00000001000,
    S_START  = 11'b00000010000,
    S_DIV    = 11'b00000100000,
    S_SUM    = 11'b00001000000,
    S_RAISE  = 11'b00010000000,
    S_LOWER  = 11'b00100000000,
    S_FINISH = 11'b01000000000,
    S_SKIP   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  // a clean point never writes the result register at accept, so it may enter
  // while an older result still waits
  assign in_ready = (state == S_IDLE) && (stat.out_free || stat.hit);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take_in = 1'b1;
          if (stat.hit) begin
            state_next = S_DIFF;
          end else begin
            cmd.emit_plain = 1'b1;
          end
        end
      end
      S_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_next    = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.skip_cond) begin
          state_next = S_SKIP;
        end else if (stat.skip_flag) begin
          cmd.clear_skip = 1'b1;
          state_next     = S_FINISH;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.load_ops = 1'b1;
        state_next   = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        cmd.latch_q1  = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.latch_q2 = 1'b1;
          state_next   = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_RAISE;
      end
      S_RAISE: begin
        cmd.raise  = 1'b1;
        state_next = S_LOWER;
      end
      S_LOWER: begin
        cmd.lower  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish_clean = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_SKIP: begin
        if (stat.out_free) begin
          cmd.finish_skip = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/adaptive_cleanup_scheduler_unit.sv =====
// Top level of the adaptive cleanup scheduler: controller plus datapath.
// Depends on acs_pkg, acs_ctrl, acs_datapath (and acs_div below it).
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | now_seconds[31:0]
//   output  | out_valid / out_ready| do_clean, clean_skipped, interval_now[31:0]
//   config  | cfg_we               | cfg_index[2:0], cfg_data[31:0]
//
// An ordinary operation writes its result into the output register when accepted.
// A clean point that adapts the interval decides, loads operands, runs the divider
// over its 45 quotient bits, then sums, clamps and finishes; a skip, or a clean
// that only clears the flag, goes from the decision straight to finishing. Synchronous
// active-high rst resets control, configuration and scheduler state, but not the
// working registers or result payload. A stalled output holds its result; ordinary
// requests wait for it, a clean point is taken and finishes once the output is free.
module adaptive_cleanup_scheduler_unit import acs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] now_seconds,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              do_clean,
  output logic              clean_skipped,
  output logic [WORD_W-1:0] interval_now
);

  acs_cmd_t  cmd;
  acs_stat_t stat;

  acs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  acs_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .now_seconds   (now_seconds),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .do_clean      (do_clean),
    .clean_skipped (clean_skipped),
    .interval_now  (interval_now)
  );

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(do_clean && clean_skipped))
    else $error("clean and skip flagged together");

  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !stat.hit) |=> (out_valid && !do_clean && !clean_skipped))
    else $error("ordinary request did not yield a plain result");

  a_clean_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && stat.hit) |=> !in_ready)
    else $error("request taken while a clean point is in progress");

endmodule
